@@ sv/mttc_pkg.sv @@
// Shared types and constants for the multi-track timed cue tracker.
// No dependencies; used by mttc_cmp and the top level by scoped names.
`default_nettype none
package mttc_pkg;
    localparam int NUM_TRACKS = 5;
    localparam int ID_TRACKS  = 4;
    localparam int TICK_W     = 23;
    localparam int TIME_W     = 24;
    localparam int OUT_ID_W   = 9;
    localparam int COUNT_W    = 7;
    localparam int OFF_W      = 7;

    // Early windows and jump threshold in ticks (480 ticks per beat).
    localparam logic [OFF_W-1:0] ID_WINDOW   = 7'd96;
    localparam logic [OFF_W-1:0] TICK_WINDOW = 7'd120;
    localparam logic signed [TIME_W:0] JUMP_TICKS = 25'sd240;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef logic [2:0] t_track;
    localparam t_track TRACK_RESING = 3'd4;

    // Request to the shared compare unit: is tick > base + offset?
    typedef struct packed {
        logic [TIME_W-1:0] base;
        logic [OFF_W-1:0]  off;
    } t_cmp_req;
endpackage
`default_nettype wire

@@ sv/mttc_cmp.sv @@
// Shared compare unit of the cue tracker: tick against a time plus a window.
// Depends on mttc_pkg.
`default_nettype none
module mttc_cmp (
    input  wire mttc_pkg::t_cmp_req              i_req,
    input  wire logic [mttc_pkg::TICK_W-1:0]     i_tick,
    output logic                                 o_gt
);
    logic [mttc_pkg::TIME_W:0] w_lhs;

    // The base is never negative here, so an unsigned compare is exact.
    always_comb begin
        w_lhs = {1'b0, i_req.base} + {{(mttc_pkg::TIME_W+1-mttc_pkg::OFF_W){1'b0}}, i_req.off};
        o_gt  = {2'b00, i_tick} > w_lhs;
    end
endmodule
`default_nettype wire

@@ sv/mttc_cue_mem.sv @@
// Cue storage: one tick memory for all tracks and one id memory for the id tracks.
// Single write port and single registered read port each. Depends on nothing.
`default_nettype none
module mttc_cue_mem #(
    parameter int TDEPTH  = 320,
    parameter int IDEPTH  = 256,
    parameter int ID_BITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_tick_we,
    input  wire logic [$clog2(TDEPTH)-1:0]   i_tick_waddr,
    input  wire logic [22:0]                 i_tick_wdata,
    input  wire logic                        i_id_we,
    input  wire logic [$clog2(IDEPTH)-1:0]   i_id_waddr,
    input  wire logic [ID_BITS-1:0]          i_id_wdata,
    input  wire logic [$clog2(TDEPTH)-1:0]   i_tick_raddr,
    input  wire logic                        i_id_re,
    input  wire logic [$clog2(IDEPTH)-1:0]   i_id_raddr,
    output logic [22:0]                      o_tick_rdata,
    output logic [ID_BITS-1:0]               o_id_rdata
);
    logic [22:0]        r_ticks [TDEPTH];
    logic [ID_BITS-1:0] r_ids   [IDEPTH];

    // Tick memory.
    always_ff @(posedge i_clk) begin
        if (i_tick_we) begin
            r_ticks[i_tick_waddr] <= i_tick_wdata;
        end
        o_tick_rdata <= r_ticks[i_tick_raddr];
    end

    // Id memory.
    always_ff @(posedge i_clk) begin
        if (i_id_we) begin
            r_ids[i_id_waddr] <= i_id_wdata;
        end
        if (i_id_re) begin
            o_id_rdata <= r_ids[i_id_raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/multi_track_timed_cue_tracker.sv @@
// Top level of the cue tracker: stream ports, sequencer, per-track state.
// Depends on mttc_pkg, mttc_cmp and mttc_cue_mem.
// A load word goes to the output state and then into the output register. A time
// update with a non-negative time seeks when looping, forced or on a jump, and walks
// the five tracks one cue at a time through one tick memory read port and one
// compare unit: each seek step and each walk step is a memory read, then a
// compare, and an update is much shorter when the tracks advance by one cue per
// update and no seek happens. The input is not ready while an item is in work or
// a result waits in the output register.
`default_nettype none
module multi_track_timed_cue_tracker #(
    parameter int MAX_CUES = 64,
    parameter int ID_BITS  = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // tdata: track[2:0], entry_slot[8:3], entry_tick[31:9], entry_id[39:32],
    // now_tick[63:40], looping[64], loop_start_tick[87:65], force_seek[88]
    input  wire logic [95:0]  s_axis_tdata,
    // tuser: operation
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: dance_id[8:0], lip_id[17:9], face_id[26:18], eyeline_id[35:27],
    // resing_fired[36], jumped[37], dance_fired_tick[60:38],
    // lip_fired_tick[83:61], face_fired_tick[106:84],
    // eyeline_fired_tick[129:107], resing_fired_tick[152:130]
    output logic [159:0]      m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [6:0]   i_cfg_data
);
    localparam int PW  = $clog2(MAX_CUES + 1);
    localparam int TDEPTH = mttc_pkg::NUM_TRACKS * MAX_CUES;
    localparam int IDEPTH = mttc_pkg::ID_TRACKS * MAX_CUES;
    localparam int TAW = $clog2(TDEPTH);
    localparam int IAW = $clog2(IDEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_SEEK_RD, ST_SEEK_CHK, ST_WALK_BEGIN, ST_WALK_RD,
        ST_WALK_CHK, ST_WALK_HIT, ST_WALK_CHK2, ST_OUT
    } t_state;

    t_state r_state;
    logic [6:0] r_count [mttc_pkg::NUM_TRACKS];
    logic [PW-1:0] r_pos [mttc_pkg::NUM_TRACKS];
    logic [mttc_pkg::NUM_TRACKS-1:0] r_done;
    logic [22:0] r_last [mttc_pkg::NUM_TRACKS];
    logic signed [23:0] r_now;
    logic [23:0] r_target;
    logic r_seek, r_jumped, r_resing;
    logic [8:0] r_ids [mttc_pkg::ID_TRACKS];
    logic [ID_BITS-1:0] r_id;
    logic [22:0] r_tk;
    mttc_pkg::t_track r_t;
    logic [PW-1:0] r_i;
    logic r_out_valid;
    logic [159:0] r_out;

    // Input field views.
    logic [2:0]  w_track;
    logic [5:0]  w_slot;
    logic [22:0] w_etick;
    logic [7:0]  w_eid;
    logic signed [23:0] w_now;
    logic        w_looping, w_force;
    logic [22:0] w_lstart;
    assign w_track   = s_axis_tdata[2:0];
    assign w_slot    = s_axis_tdata[8:3];
    assign w_etick   = s_axis_tdata[31:9];
    assign w_eid     = s_axis_tdata[39:32];
    assign w_now     = s_axis_tdata[63:40];
    assign w_looping = s_axis_tdata[64];
    assign w_lstart  = s_axis_tdata[87:65];
    assign w_force   = s_axis_tdata[88];

    logic w_in_acc;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;

    // Cue count of the current track, clamped to the capacity.
    logic [PW-1:0] w_n;
    always_comb begin
        if (32'(r_count[r_t]) > MAX_CUES) begin
            w_n = PW'(MAX_CUES);
        end else begin
            w_n = PW'(r_count[r_t]);
        end
    end

    logic [PW-1:0] w_i1;
    assign w_i1 = r_i + PW'(1);

    // Load addressing.
    logic w_load_ok;
    logic [TAW-1:0] w_twaddr;
    logic [IAW-1:0] w_iwaddr;
    logic [ID_BITS+7:0] w_eid_ext;
    always_comb begin
        w_load_ok = (32'(w_track) < mttc_pkg::NUM_TRACKS) && (32'(w_slot) < MAX_CUES);
        w_twaddr  = TAW'(w_track) * TAW'(MAX_CUES) + TAW'(w_slot);
        w_iwaddr  = IAW'(w_track) * IAW'(MAX_CUES) + IAW'(w_slot);
        w_eid_ext = {{ID_BITS{1'b0}}, w_eid};
    end

    // Read address: the next cue in the walk hit state, else the current one.
    logic [PW-1:0]  w_ri;
    logic [TAW-1:0] w_traddr;
    logic [IAW-1:0] w_iraddr;
    logic w_id_re;
    always_comb begin
        w_ri = (r_state == ST_WALK_HIT) ? w_i1 : r_i;
        w_traddr = TAW'(r_t) * TAW'(MAX_CUES) + TAW'(w_ri);
        w_iraddr = IAW'(r_t[1:0]) * IAW'(MAX_CUES) + IAW'(w_ri);
        w_id_re = (r_t != mttc_pkg::TRACK_RESING);
    end

    logic [22:0] w_tick_rd;
    logic [ID_BITS-1:0] w_id_rd;

    mttc_cue_mem #(.TDEPTH(TDEPTH), .IDEPTH(IDEPTH), .ID_BITS(ID_BITS)) u_mem (
        .i_clk       (i_clk),
        .i_tick_we   (w_in_acc && s_axis_tuser == mttc_pkg::OP_LOAD && w_load_ok),
        .i_tick_waddr(w_twaddr),
        .i_tick_wdata(w_etick),
        .i_id_we     (w_in_acc && s_axis_tuser == mttc_pkg::OP_LOAD && w_load_ok
                      && w_track != mttc_pkg::TRACK_RESING),
        .i_id_waddr  (w_iwaddr),
        .i_id_wdata  (w_eid_ext[ID_BITS-1:0]),
        .i_tick_raddr(w_traddr),
        .i_id_re     (w_id_re),
        .i_id_raddr  (w_iraddr),
        .o_tick_rdata(w_tick_rd),
        .o_id_rdata  (w_id_rd)
    );

    // Shared compare: seek uses the target, walk uses now plus the window.
    mttc_pkg::t_cmp_req w_req;
    logic w_gt;
    always_comb begin
        if (r_state == ST_SEEK_CHK) begin
            w_req.base = r_target;
            w_req.off  = '0;
        end else begin
            w_req.base = r_now;
            w_req.off  = (r_t == mttc_pkg::TRACK_RESING) ? mttc_pkg::TICK_WINDOW
                                                         : mttc_pkg::ID_WINDOW;
        end
    end

    mttc_cmp u_cmp (.i_req(w_req), .i_tick(w_tick_rd), .o_gt(w_gt));

    // Signed step from the held time to the new one.
    logic signed [24:0] w_diff;
    assign w_diff = 25'(w_now) - 25'(r_now);

    logic [ID_BITS+8:0] w_rid_ext;
    assign w_rid_ext = {9'b0, r_id};

    // Sequencer, per-track state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_done <= '0;
            r_now <= '0;
            for (int k = 0; k < mttc_pkg::NUM_TRACKS; k++) begin
                r_count[k] <= '0;
                r_pos[k] <= '0;
                r_last[k] <= '0;
            end
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && 32'(i_cfg_index) < mttc_pkg::NUM_TRACKS) begin
                r_count[i_cfg_index] <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        for (int k = 0; k < mttc_pkg::ID_TRACKS; k++) begin
                            r_ids[k] <= '1;
                        end
                        r_resing <= 1'b0;
                        r_jumped <= 1'b0;
                        r_t <= '0;
                        r_state <= ST_OUT;
                        if (s_axis_tuser == mttc_pkg::OP_UPDATE) begin
                            r_now <= w_now;
                            if (!w_now[23]) begin
                                r_state <= ST_START;
                                r_seek <= 1'b0;
                                if (w_looping) begin
                                    r_seek <= 1'b1;
                                    r_target <= {1'b0, w_lstart};
                                end else if (w_diff > mttc_pkg::JUMP_TICKS || w_force) begin
                                    r_seek <= 1'b1;
                                    r_jumped <= 1'b1;
                                    r_target <= w_now;
                                end
                            end
                        end
                    end
                end
                ST_START: begin
                    r_i <= '0;
                    r_state <= r_seek ? ST_SEEK_RD : ST_WALK_BEGIN;
                end
                ST_SEEK_RD: begin
                    if (r_i >= w_n) begin
                        r_i <= '0;
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_t <= '0;
                            r_state <= ST_WALK_BEGIN;
                        end else begin
                            r_t <= r_t + 3'd1;
                        end
                    end else begin
                        r_state <= ST_SEEK_CHK;
                    end
                end
                ST_SEEK_CHK: begin
                    if (w_gt) begin
                        r_pos[r_t] <= (r_i == '0) ? '0 : r_i - PW'(1);
                        r_done[r_t] <= 1'b0;
                        r_i <= '0;
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_t <= '0;
                            r_state <= ST_WALK_BEGIN;
                        end else begin
                            r_t <= r_t + 3'd1;
                            r_state <= ST_SEEK_RD;
                        end
                    end else begin
                        r_i <= w_i1;
                        r_state <= ST_SEEK_RD;
                    end
                end
                ST_WALK_BEGIN: begin
                    r_i <= r_pos[r_t];
                    if (r_done[r_t] || r_pos[r_t] >= w_n) begin
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_t <= r_t + 3'd1;
                        end
                    end else begin
                        r_state <= ST_WALK_RD;
                    end
                end
                ST_WALK_RD: begin
                    r_state <= ST_WALK_CHK;
                end
                ST_WALK_CHK: begin
                    if (!w_gt) begin
                        r_tk <= w_tick_rd;
                        r_id <= w_id_rd;
                        r_state <= ST_WALK_HIT;
                    end else if (w_i1 >= w_n) begin
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_t <= r_t + 3'd1;
                            r_state <= ST_WALK_BEGIN;
                        end
                    end else begin
                        r_i <= w_i1;
                        r_state <= ST_WALK_RD;
                    end
                end
                ST_WALK_HIT: begin
                    // The current cue is in its window; the last cue fires at once.
                    if (w_i1 == w_n) begin
                        r_done[r_t] <= 1'b1;
                        r_last[r_t] <= r_tk;
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_resing <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_ids[r_t[1:0]] <= w_rid_ext[8:0];
                            r_t <= r_t + 3'd1;
                            r_state <= ST_WALK_BEGIN;
                        end
                    end else begin
                        r_state <= ST_WALK_CHK2;
                    end
                end
                ST_WALK_CHK2: begin
                    if (w_gt) begin
                        r_pos[r_t] <= w_i1;
                        r_last[r_t] <= r_tk;
                        if (r_t == mttc_pkg::TRACK_RESING) begin
                            r_resing <= 1'b1;
                            r_state <= ST_OUT;
                        end else begin
                            r_ids[r_t[1:0]] <= w_rid_ext[8:0];
                            r_t <= r_t + 3'd1;
                            r_state <= ST_WALK_BEGIN;
                        end
                    end else begin
                        // The next cue is in its window as well: move on to it.
                        r_i <= w_i1;
                        r_tk <= w_tick_rd;
                        r_id <= w_id_rd;
                        r_state <= ST_WALK_HIT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out <= {7'b0, r_last[4], r_last[3], r_last[2], r_last[1],
                                  r_last[0], r_jumped, r_resing, r_ids[3], r_ids[2],
                                  r_ids[1], r_ids[0]};
                        r_out_valid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // The input is closed while an item is in work.
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");

    // A walk never reads beyond the cues in use.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK_CHK || r_state == ST_WALK_HIT) |-> (r_i < w_n))
        else $error("walk index beyond cue count");

    // A load word goes straight to the output stage.
    a_load_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser == mttc_pkg::OP_LOAD) |=> (r_state == ST_OUT))
        else $error("load did not go to output");
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the multi-track timed cue tracker: it drives load and update
// words, predicts every result word and checks each output field against that prediction.
// Depends on mttc_pkg and multi_track_timed_cue_tracker.
`default_nettype none
module tb_top;
    localparam int CUES      = 64;
    localparam int WIN_ID    = 96;
    localparam int WIN_TICK  = 120;
    localparam int JUMP_LIM  = 240;
    localparam int CYCLE_MAX = 10_000_000;
    localparam int TICK_MAX  = 8388607;

    typedef struct {
        logic         op;
        logic [95:0]  data;
    } t_word;

    typedef struct {
        logic [8:0]                  ids [mttc_pkg::ID_TRACKS];
        logic                        resing;
        logic                        jumped;
        logic [mttc_pkg::TICK_W-1:0] fired [mttc_pkg::NUM_TRACKS];
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [95:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [6:0]   i_cfg_data = '0;

    multi_track_timed_cue_tracker u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the tracker state.
    int unsigned cue_tick_mem [mttc_pkg::NUM_TRACKS][CUES];
    int unsigned cue_id_mem [mttc_pkg::ID_TRACKS][CUES];
    int unsigned trk_pos [mttc_pkg::NUM_TRACKS];
    bit          trk_done [mttc_pkg::NUM_TRACKS];
    int unsigned trk_count [mttc_pkg::NUM_TRACKS];
    int unsigned last_fired [mttc_pkg::NUM_TRACKS];
    int          time_cur;
    int          time_prev;

    t_word   pending_words [$];
    t_result expected_results [$];
    int      mismatches;
    int      cycles;
    bit      idle_free;

    function automatic int unsigned used_cues(int t);
        return (trk_count[t] > CUES) ? CUES : trk_count[t];
    endfunction

    function automatic void seek_cues(int t, int target);
        int unsigned n;
        n = used_cues(t);
        for (int unsigned i = 0; i < n; i++) begin
            if (int'(cue_tick_mem[t][i]) > target) begin
                trk_pos[t] = (i == 0) ? 0 : i - 1;
                trk_done[t] = 1'b0;
                return;
            end
        end
    endfunction

    // Returns the fired slot, or -1 when the track fires nothing.
    function automatic int walk_cues(int t, int win);
        int unsigned n;
        int unsigned i;
        int          tk;
        n = used_cues(t);
        i = trk_pos[t];
        if (n < 1 || trk_done[t] || i >= n) return -1;
        forever begin
            tk = int'(cue_tick_mem[t][i]);
            if (time_cur >= tk - win) begin
                if (i + 1 == n) begin
                    trk_done[t] = 1'b1;
                    last_fired[t] = unsigned'(tk);
                    return int'(i);
                end
                if (time_cur < int'(cue_tick_mem[t][i+1]) - win) begin
                    trk_pos[t] = i + 1;
                    last_fired[t] = unsigned'(tk);
                    return int'(i);
                end
            end
            i++;
            if (i >= n) return -1;
        end
    endfunction

    function automatic t_result predict_cue_result(t_word w);
        t_result r;
        int      idx;
        int      tr;
        int      slot;
        for (int t = 0; t < mttc_pkg::ID_TRACKS; t++) r.ids[t] = 9'h1FF;
        r.resing = 1'b0;
        r.jumped = 1'b0;
        if (w.op == mttc_pkg::OP_LOAD) begin
            tr = int'(w.data[2:0]);
            slot = int'(w.data[8:3]);
            if (tr < mttc_pkg::NUM_TRACKS) begin
                cue_tick_mem[tr][slot] = 32'(w.data[31:9]);
                if (tr < mttc_pkg::ID_TRACKS) cue_id_mem[tr][slot] = 32'(w.data[39:32]);
            end
        end else begin
            time_prev = time_cur;
            time_cur = int'($signed(w.data[63:40]));
            if (time_cur >= 0) begin
                if (w.data[64]) begin
                    for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++)
                        seek_cues(t, int'(w.data[87:65]));
                end else if (time_cur - time_prev > JUMP_LIM || w.data[88]) begin
                    for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++) seek_cues(t, time_cur);
                    r.jumped = 1'b1;
                end
                for (int t = 0; t < mttc_pkg::ID_TRACKS; t++) begin
                    idx = walk_cues(t, WIN_ID);
                    if (idx >= 0) r.ids[t] = {1'b0, cue_id_mem[t][idx][7:0]};
                end
                r.resing = (walk_cues(int'(mttc_pkg::TRACK_RESING), WIN_TICK) >= 0);
            end
        end
        for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++)
            r.fired[t] = last_fired[t][mttc_pkg::TICK_W-1:0];
        return r;
    endfunction

    // Queue builders; fields not used by the operation carry random noise.
    task automatic add_load(int t, int slot, int tick, int id);
        t_word w;
        w.op = mttc_pkg::OP_LOAD;
        w.data = {$urandom, $urandom, $urandom};
        w.data[95:89] = '0;
        w.data[2:0] = 3'(t);
        w.data[8:3] = 6'(slot);
        w.data[31:9] = 23'(tick);
        w.data[39:32] = 8'(id);
        pending_words.push_back(w);
    endtask

    task automatic add_update(int now, bit loop, int loop_start, bit force_seek);
        t_word w;
        w.op = mttc_pkg::OP_UPDATE;
        w.data = {$urandom, $urandom, $urandom};
        w.data[95:89] = '0;
        w.data[63:40] = 24'(now);
        w.data[64] = loop;
        w.data[87:65] = 23'(loop_start);
        w.data[88] = force_seek;
        pending_words.push_back(w);
    endtask

    // Writes a sorted cue list to slots 0..n-1 of one track, up to slot CUES-1.
    task automatic fill_track(int t, int n, int base, int max_gap);
        int tick;
        tick = base;
        for (int s = 0; s < n && s < CUES; s++) begin
            add_load(t, s, (tick > TICK_MAX) ? TICK_MAX : tick, int'($urandom_range(255)));
            tick += int'($urandom_range(max_gap, 20));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    endtask

    // Register writes through the configuration channel; the block is idle here.
    task automatic write_counts(int c0, int c1, int c2, int c3, int c4);
        int vals [mttc_pkg::NUM_TRACKS];
        vals = '{c0, c1, c2, c3, c4};
        @(posedge i_clk);
        for (int r = 0; r < mttc_pkg::NUM_TRACKS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data <= 7'(vals[r]);
            trk_count[r] = unsigned'(vals[r]);
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_count();
        int k;
        k = int'($urandom_range(19));
        if (k == 0) return 0;
        if (k == 1) return 1;
        if (k == 2) return int'($urandom_range(127, 65));
        return int'($urandom_range(10, 2));
    endfunction

    // Driver: presents queued words, with random gaps outside the idle-free phases.
    int gap_left = 0;
    t_word cur_word;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_cue_result(cur_word));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    s_axis_tuser <= cur_word.op;
                    s_axis_tdata <= cur_word.data;
                    s_axis_tvalid <= 1'b1;
                    if (!idle_free)
                        gap_left = ($urandom_range(9) < 7) ? int'($urandom_range(2))
                                 : ($urandom_range(9) == 0) ? int'($urandom_range(60, 20))
                                 : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result want;
        bit      bad;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: %h", m_axis_tdata);
                end else begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    for (int t = 0; t < mttc_pkg::ID_TRACKS; t++)
                        if (m_axis_tdata[t*9 +: 9] !== want.ids[t]) bad = 1'b1;
                    if (m_axis_tdata[36] !== want.resing) bad = 1'b1;
                    if (m_axis_tdata[37] !== want.jumped) bad = 1'b1;
                    for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++)
                        if (m_axis_tdata[38 + t*mttc_pkg::TICK_W +: mttc_pkg::TICK_W]
                            !== want.fired[t]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: ids exp %h %h %h %h resing %b jumped %b",
                                want.ids[0], want.ids[1], want.ids[2], want.ids[3],
                                want.resing, want.jumped,
                                " ticks exp %h %h %h %h %h, actual word %h",
                                want.fired[0], want.fired[1], want.fired[2],
                                want.fired[3], want.fired[4], m_axis_tdata);
                    end
                end
            end
            // Outside the idle-free phases: mostly short random stalls, now and then a long one.
            if (idle_free) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(63) == 0) begin
                stall_left = int'($urandom_range(60, 20));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(15) == 0) ? 1'b0 : ($urandom_range(3) != 0);
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus in phases; counts change only while the block is drained.
    initial begin
        int base;
        int now;
        int cnt [mttc_pkg::NUM_TRACKS];
        int upd;
        int k;
        mismatches = 0;
        cycles = 0;
        idle_free = 1'b0;
        time_cur = 0;
        time_prev = 0;
        for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++) begin
            trk_pos[t] = 0;
            trk_done[t] = 1'b0;
            trk_count[t] = 0;
            last_fired[t] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: three cues per track, extremes, every kind of update.
        write_counts(3, 3, 3, 3, 3);
        for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++)
            for (int s = 0; s < 3; s++) add_load(t, s, 200 + s * 300, (s == 2) ? 255 : s);
        add_load(5, 10, TICK_MAX, 255);
        add_load(7, 63, 0, 0);
        add_update(-8388608, 0, 0, 0);
        add_update(110, 0, 0, 0);
        add_update(150, 0, 0, 0);
        add_update(420, 0, 0, 0);
        add_update(900, 0, 0, 0);
        add_update(905, 0, 0, 1);
        add_update(120, 1, 0, 0);
        add_update(8388607, 0, 0, 0);
        add_update(8388607, 0, TICK_MAX, 1);
        add_update(0, 1, TICK_MAX, 0);
        wait_drained();

        // Random phases.
        for (int ph = 0; ph < 14; ph++) begin
            for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++) cnt[t] = pick_count();
            if (ph == 5) cnt = '{64, 64, 64, 64, 64};
            if (ph == 9) cnt = '{127, 0, 64, 1, 127};
            if (ph == 13) cnt = '{0, 0, 0, 0, 0};
            write_counts(cnt[0], cnt[1], cnt[2], cnt[3], cnt[4]);
            idle_free = (ph % 4 == 3);
            base = (ph == 7) ? 8388000 : int'($urandom_range(20000));
            for (int t = 0; t < mttc_pkg::NUM_TRACKS; t++)
                fill_track(t, cnt[t], base + int'($urandom_range(100)), (ph == 7) ? 30 : 300);
            now = base - 200;
            upd = (ph == 5 || ph == 9) ? 40 : 50;
            for (int u = 0; u < upd; u++) begin
                k = int'($urandom_range(99));
                if (k < 4) begin
                    add_update(-int'($urandom_range(8388608, 1)), 1'b0, 0,
                               1'($urandom_range(1)));
                end else if (k < 7) begin
                    now = base + int'($urandom_range(500));
                    add_update(now, 1'b1, base + int'($urandom_range(300)),
                               1'($urandom_range(1)));
                end else if (k < 11) begin
                    now += int'($urandom_range(1500, 241));
                    add_update(now, 1'b0, int'($urandom_range(TICK_MAX)), 1'b0);
                end else if (k < 13) begin
                    add_update(now, 1'b0, int'($urandom_range(TICK_MAX)), 1'b1);
                end else if (k < 15) begin
                    now = int'($urandom_range(TICK_MAX));
                    add_update(int'($urandom), 1'($urandom_range(1)),
                               int'($urandom_range(TICK_MAX)), 1'($urandom_range(1)));
                end else if (k < 19) begin
                    add_load(int'($urandom_range(7)), int'($urandom_range(63)),
                             int'($urandom_range(TICK_MAX)), int'($urandom_range(255)));
                end else begin
                    now += int'($urandom_range(120));
                    add_update(now, 1'b0, int'($urandom_range(TICK_MAX)), 1'b0);
                end
                if (now > TICK_MAX) now = base;
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
